// File: rtl/pur_pkg.sv
package pur_pkg;

  // Field and datapath widths
  localparam int PIX_W   = 16;  // pixel coordinates, center, Q12.4
  localparam int FOC_W   = 24;  // focal lengths, Q16.8
  localparam int OFS_W   = 24;  // signed offsets, Q20.4
  localparam int CFG_W   = 24;  // widest register
  localparam int ADDR_W  = 3;
  localparam int DIFF_W  = 26;  // u - cx - tx, signed
  localparam int MAG_W   = 24;  // |u - cx - tx|
  localparam int PROD_W  = 52;  // 16 * |d| * f
  localparam int LEN_W   = 6;   // bit length of a PROD_W word
  localparam int SHIFT_W = 5;   // block normalization shift
  localparam int NRM_W   = 31;  // normalized magnitudes
  localparam int SQ_W    = 64;  // sum of squares
  localparam int ROOT_W  = 32;
  localparam int REM_W   = ROOT_W + 3;
  localparam int Q_W     = 16;  // quotient bits, enough for 2^15
  localparam int NUM_W   = NRM_W + Q_W + 1;
  localparam int OUT_W   = 16;
  localparam int Z_W     = 15;
  localparam int IN_TDATA_W  = 2 * PIX_W;
  localparam int OUT_TDATA_W = 48;

  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = Q_W;

  localparam logic [Q_W-1:0] Q15_MAX = 16'd32767;

  localparam logic [FOC_W-1:0] FOCAL_RST    = 24'd131072;
  localparam logic [PIX_W-1:0] CENTER_X_RST = 16'd5120;
  localparam logic [PIX_W-1:0] CENTER_Y_RST = 16'd3840;

  typedef enum logic [ADDR_W-1:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5
  } cfg_reg_t;

endpackage

// File: rtl/pixel_to_unit_ray.sv
// Channel  | Direction | Handshake         | Payload (low bit first)
// s_*      | in        | s_tvalid/s_tready | pixel_u[15:0], pixel_v[31:16]
// m_*      | out       | m_tvalid/m_tready | ray_x[15:0], ray_y[31:16], ray_z[46:32], 0
// cfg_*    | in        | cfg_we            | cfg_addr index, cfg_data value
//
// One item per cycle while no stall on m_tready holds the pipeline; items pass
// through the front stages, the 32-stage square root and the 16-stage dividers.
// Reset (rst, synchronous) clears all valid bits and loads register defaults.
// A stall on m_tready holds the whole pipeline; s_tready follows it, so the
// next item is taken in the same cycle the waiting result leaves.
module pixel_to_unit_ray (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pur_pkg::IN_TDATA_W-1:0]      s_tdata,   // pixel_u, pixel_v
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pur_pkg::OUT_TDATA_W-1:0]     m_tdata,   // ray_x, ray_y, ray_z, pad
  input  logic                                cfg_we,
  input  logic [pur_pkg::ADDR_W-1:0]          cfg_addr,
  input  logic [pur_pkg::CFG_W-1:0]           cfg_data
);
  import pur_pkg::*;

  // stage positions in the valid line
  localparam int V_SUM  = 5;
  localparam int V_SH   = 3;
  localparam int V_ROOT = V_SUM + SQRT_STAGES;
  localparam int V_QUO  = V_ROOT + 1 + DIV_STAGES;
  localparam int LAT    = V_QUO + 2;
  localparam int D_MAG  = V_ROOT - V_SH + 1;

  // configuration registers
  logic [FOC_W-1:0] focal_x, focal_y;
  logic [PIX_W-1:0] center_x, center_y;
  logic [OFS_W-1:0] offset_x, offset_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= FOCAL_RST;
      focal_y  <= FOCAL_RST;
      center_x <= CENTER_X_RST;
      center_y <= CENTER_Y_RST;
      offset_x <= '0;
      offset_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FOCAL_X:  focal_x  <= cfg_data[FOC_W-1:0];
        REG_FOCAL_Y:  focal_y  <= cfg_data[FOC_W-1:0];
        REG_CENTER_X: center_x <= cfg_data[PIX_W-1:0];
        REG_CENTER_Y: center_y <= cfg_data[PIX_W-1:0];
        REG_OFFSET_X: offset_x <= cfg_data[OFS_W-1:0];
        REG_OFFSET_Y: offset_y <= cfg_data[OFS_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // a zero focal length acts as one LSB
  logic [FOC_W-1:0] fx_eff, fy_eff;
  assign fx_eff = (focal_x == '0) ? FOC_W'(1) : focal_x;
  assign fy_eff = (focal_y == '0) ? FOC_W'(1) : focal_y;

  // global advance: move when the output slot is free or being taken
  logic adv;
  logic [LAT-1:0] vld;
  assign adv      = m_tready || !m_tvalid;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // sign bits ride along to the output stage
  logic sx [V_QUO+1];
  logic sy [V_QUO+1];

  // stage 1: offsets from the principal point, split into sign and magnitude
  logic signed [DIFF_W-1:0] dx_c, dy_c, ax_c, ay_c;
  logic [MAG_W-1:0] mag_x, mag_y;

  always_comb begin
    dx_c = $signed({{(DIFF_W-PIX_W){1'b0}}, s_tdata[PIX_W-1:0]})
         - $signed({{(DIFF_W-PIX_W){1'b0}}, center_x})
         - $signed({{(DIFF_W-OFS_W){offset_x[OFS_W-1]}}, offset_x});
    dy_c = $signed({{(DIFF_W-PIX_W){1'b0}}, s_tdata[2*PIX_W-1:PIX_W]})
         - $signed({{(DIFF_W-PIX_W){1'b0}}, center_y})
         - $signed({{(DIFF_W-OFS_W){offset_y[OFS_W-1]}}, offset_y});
    ax_c = dx_c[DIFF_W-1] ? -dx_c : dx_c;
    ay_c = dy_c[DIFF_W-1] ? -dy_c : dy_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_x <= ax_c[MAG_W-1:0];
      mag_y <= ay_c[MAG_W-1:0];
      sx[0] <= dx_c[DIFF_W-1];
      sy[0] <= dy_c[DIFF_W-1];
    end
  end

  generate
    for (genvar j = 1; j <= V_QUO; j++) begin : g_sign
      always_ff @(posedge clk) begin
        if (adv) begin
          sx[j] <= sx[j-1];
          sy[j] <= sy[j-1];
        end
      end
    end
  endgenerate

  // stage 2: scale the ray by 16 * fx * fy
  logic [2*FOC_W-1:0] mx_c, my_c, mz_c;
  logic [PROD_W-1:0]  pa, pb, pc;

  assign mx_c = (2*FOC_W)'(mag_x) * (2*FOC_W)'(fy_eff);
  assign my_c = (2*FOC_W)'(mag_y) * (2*FOC_W)'(fx_eff);
  assign mz_c = (2*FOC_W)'(fx_eff) * (2*FOC_W)'(fy_eff);

  always_ff @(posedge clk) begin
    if (adv) begin
      pa <= {mx_c, 4'b0000};
      pb <= {my_c, 4'b0000};
      pc <= PROD_W'(mz_c);
    end
  end

  // stage 3: block normalization shift from the bit length of the largest
  logic [PROD_W-1:0]  m_or;
  logic [LEN_W-1:0]   blen;
  logic [SHIFT_W-1:0] k_c, k;
  logic [PROD_W-1:0]  pa3, pb3, pc3;

  always_comb begin
    m_or = pa | pb | pc;
    blen = '0;
    for (int i = 0; i < PROD_W; i++) begin
      if (m_or[i]) blen = LEN_W'(i + 1);
    end
    k_c = (blen > LEN_W'(NRM_W)) ? SHIFT_W'(blen - LEN_W'(NRM_W)) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k   <= k_c;
      pa3 <= pa;
      pb3 <= pb;
      pc3 <= pc;
    end
  end

  // stage 4: apply the shift; magnitudes then travel to the dividers
  logic [NRM_W-1:0] na [D_MAG];
  logic [NRM_W-1:0] nb [D_MAG];
  logic [NRM_W-1:0] nc [D_MAG];
  logic [PROD_W-1:0] sa_c, sb_c, sc_c;

  assign sa_c = pa3 >> k;
  assign sb_c = pb3 >> k;
  assign sc_c = pc3 >> k;

  always_ff @(posedge clk) begin
    if (adv) begin
      na[0] <= sa_c[NRM_W-1:0];
      nb[0] <= sb_c[NRM_W-1:0];
      nc[0] <= sc_c[NRM_W-1:0];
    end
  end

  generate
    for (genvar j = 1; j < D_MAG; j++) begin : g_mag
      always_ff @(posedge clk) begin
        if (adv) begin
          na[j] <= na[j-1];
          nb[j] <= nb[j-1];
          nc[j] <= nc[j-1];
        end
      end
    end
  endgenerate

  // stage 5: squares; stage 6: their sum
  logic [SQ_W-1:0] sqa, sqb, sqc, nsum;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqa  <= SQ_W'(na[0]) * SQ_W'(na[0]);
      sqb  <= SQ_W'(nb[0]) * SQ_W'(nb[0]);
      sqc  <= SQ_W'(nc[0]) * SQ_W'(nc[0]);
      nsum <= sqa + sqb + sqc;
    end
  end

  // square root of the sum
  logic [ROOT_W-1:0] root;

  pur_isqrt u_isqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (nsum),
    .root     (root)
  );

  // one divider lane per component
  logic [Q_W-1:0] quo_x, quo_y, quo_z;

  pur_div u_div_x (.clk(clk), .en(adv), .mag(na[D_MAG-1]), .root(root), .quo(quo_x));
  pur_div u_div_y (.clk(clk), .en(adv), .mag(nb[D_MAG-1]), .root(root), .quo(quo_y));
  pur_div u_div_z (.clk(clk), .en(adv), .mag(nc[D_MAG-1]), .root(root), .quo(quo_z));

  // output stage: saturate and restore signs
  logic [Q_W-1:0]   sat_x, sat_y, sat_z;
  logic [OUT_W-1:0] ray_x, ray_y;

  always_comb begin
    sat_x = (quo_x > Q15_MAX) ? Q15_MAX : quo_x;
    sat_y = (quo_y > Q15_MAX) ? Q15_MAX : quo_y;
    sat_z = (quo_z > Q15_MAX) ? Q15_MAX : quo_z;
    ray_x = sx[V_QUO] ? OUT_W'(-sat_x) : OUT_W'(sat_x);
    ray_y = sy[V_QUO] ? OUT_W'(-sat_y) : OUT_W'(sat_y);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {1'b0, sat_z[Z_W-1:0], ray_y, ray_x};
    end
  end

  // saturation never lets a component reach -1.0
  a_no_min: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000))
    else $error("ray component reached -1.0");

  // a stall freezes the valid line
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("valid line moved during a stall");

  // the sum of squares is never zero, so the root is not either
  a_root_nz: assert property (@(posedge clk) disable iff (rst)
    vld[V_ROOT] |-> (root != '0))
    else $error("zero square root");

  // the normalized x and z components never exceed one
  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    vld[V_QUO] |-> (quo_x <= Q15_MAX + 16'd1) && (quo_z <= Q15_MAX + 16'd1))
    else $error("quotient out of range");

endmodule

// File: rtl/pur_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module pur_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [pur_pkg::SQ_W-1:0]   radicand,
  output logic [pur_pkg::ROOT_W-1:0] root
);
  import pur_pkg::*;

  logic [SQ_W-1:0]   n_sh [SQRT_STAGES];
  logic [REM_W-1:0]  rem  [SQRT_STAGES];
  logic [ROOT_W-1:0] rt   [SQRT_STAGES];

  generate
    for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_step
      logic [SQ_W-1:0]   n_in;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] rt_in;
      logic [REM_W-1:0]  cand;
      logic [REM_W-1:0]  trial;

      if (i == 0) begin : g_first
        assign n_in   = radicand;
        assign rem_in = '0;
        assign rt_in  = '0;
      end else begin : g_rest
        assign n_in   = n_sh[i-1];
        assign rem_in = rem[i-1];
        assign rt_in  = rt[i-1];
      end

      // bring down the next two radicand bits, try 4*root + 1
      assign cand  = {rem_in[REM_W-3:0], n_in[SQ_W-1 -: 2]};
      assign trial = {1'b0, rt_in, 2'b01};

      always_ff @(posedge clk) begin
        if (en) begin
          n_sh[i] <= {n_in[SQ_W-3:0], 2'b00};
          if (cand >= trial) begin
            rem[i] <= cand - trial;
            rt[i]  <= {rt_in[ROOT_W-2:0], 1'b1};
          end else begin
            rem[i] <= cand;
            rt[i]  <= {rt_in[ROOT_W-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign root = rt[SQRT_STAGES-1];

endmodule

// File: rtl/pur_div.sv
// Pipelined restoring divider: quo = floor((mag * 2^16 + s) / (2 * s)).
module pur_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [pur_pkg::NRM_W-1:0]  mag,
  input  logic [pur_pkg::ROOT_W-1:0] root,
  output logic [pur_pkg::Q_W-1:0]    quo
);
  import pur_pkg::*;

  logic [NUM_W-1:0]  num_p;
  logic [ROOT_W:0]   den_p;
  logic [NUM_W-1:0]  part [DIV_STAGES];
  logic [ROOT_W:0]   den  [DIV_STAGES];
  logic [Q_W-1:0]    q    [DIV_STAGES];

  // form numerator and denominator
  always_ff @(posedge clk) begin
    if (en) begin
      num_p <= NUM_W'({mag, {Q_W{1'b0}}}) + NUM_W'(root);
      den_p <= {root, 1'b0};
    end
  end

  generate
    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
      localparam int B = DIV_STAGES - 1 - i;
      logic [NUM_W-1:0] part_in;
      logic [ROOT_W:0]  den_in;
      logic [Q_W-1:0]   q_in;
      logic [NUM_W:0]   sub;

      if (i == 0) begin : g_first
        assign part_in = num_p;
        assign den_in  = den_p;
        assign q_in    = '0;
      end else begin : g_rest
        assign part_in = part[i-1];
        assign den_in  = den[i-1];
        assign q_in    = q[i-1];
      end

      assign sub = (NUM_W+1)'(den_in) << B;

      always_ff @(posedge clk) begin
        if (en) begin
          den[i] <= den_in;
          if ({1'b0, part_in} >= sub) begin
            part[i] <= NUM_W'({1'b0, part_in} - sub);
            q[i]    <= {q_in[Q_W-2:0], 1'b1};
          end else begin
            part[i] <= part_in;
            q[i]    <= {q_in[Q_W-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign quo = q[DIV_STAGES-1];

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import pur_pkg::*;

  // Indexes past the last register; the block must drop writes to these
  localparam logic [ADDR_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [ADDR_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int PIPE_WAIT   = 80;    // a bit more than the pipeline latency
  localparam int STALL_LIMIT = 5000;  // cycles with no item moving
  localparam int RAND_ITEMS  = 1400;
  localparam int NUM_SETS    = 8;

  typedef struct packed {
    logic [Z_W-1:0]   z;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] x;
  } unit_ray_t;

  // Holds a copy of the camera registers and the rays still owed by the block
  class ray_scoreboard;
    logic [FOC_W-1:0] focal_x, focal_y;
    logic [PIX_W-1:0] center_x, center_y;
    logic [OFS_W-1:0] offset_x, offset_y;
    unit_ray_t        owed_rays[$];
    int               errors;

    function new();
      focal_x  = FOCAL_RST;
      focal_y  = FOCAL_RST;
      center_x = CENTER_X_RST;
      center_y = CENTER_Y_RST;
      offset_x = '0;
      offset_y = '0;
      errors   = 0;
    endfunction

    function void set_reg(logic [ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_FOCAL_X:  focal_x  = val;
        REG_FOCAL_Y:  focal_y  = val;
        REG_CENTER_X: center_x = val[PIX_W-1:0];
        REG_CENTER_Y: center_y = val[PIX_W-1:0];
        REG_OFFSET_X: offset_x = val;
        REG_OFFSET_Y: offset_y = val;
        default: ;
      endcase
    endfunction

    function longint unsigned floor_root(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n    = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    // Round half away from zero, clip a full-length component to 32767
    function longint unsigned unit_mag(longint unsigned m, longint unsigned s);
      longint unsigned r;
      r = ((m << 16) + s) / (s << 1);
      return (r > 32767) ? 64'd32767 : r;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] u, logic [PIX_W-1:0] v);
      longint fxv, fyv, dx, dy, rx, ry;
      longint unsigned a, b, c, mx, s;
      int k;
      unit_ray_t ray;
      // A zero focal length acts as one LSB
      fxv = (focal_x == 0) ? 64'sd1 : longint'(focal_x);
      fyv = (focal_y == 0) ? 64'sd1 : longint'(focal_y);
      dx = longint'(u) - longint'(center_x) - longint'($signed(offset_x));
      dy = longint'(v) - longint'(center_y) - longint'($signed(offset_y));
      rx = dx * 16 * fyv;
      ry = dy * 16 * fxv;
      a = (rx < 0) ? -rx : rx;
      b = (ry < 0) ? -ry : ry;
      c = fxv * fyv;
      mx = a;
      if (b > mx) mx = b;
      if (c > mx) mx = c;
      k = 0;
      while ((mx >> k) >= 64'h8000_0000) k++;
      a >>= k;
      b >>= k;
      c >>= k;
      s = floor_root(a * a + b * b + c * c);
      if (s == 0) s = 1;
      ray.x = OUT_W'((rx < 0) ? -unit_mag(a, s) : unit_mag(a, s));
      ray.y = OUT_W'((ry < 0) ? -unit_mag(b, s) : unit_mag(b, s));
      ray.z = Z_W'(unit_mag(c, s));
      owed_rays.push_back(ray);
    endfunction

    function void check_ray(logic [OUT_TDATA_W-1:0] data);
      unit_ray_t want, got;
      got = data[Z_W+2*OUT_W-1:0];
      if (owed_rays.size() == 0) begin
        $display("%0t: ray with none owed: got %h", $time, got);
        errors++;
        return;
      end
      want = owed_rays.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: ray_x expected %h actual %h", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: ray_y expected %h actual %h", $time, want.y, got.y);
        errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: ray_z expected %h actual %h", $time, want.z, got.z);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // pixel_u, pixel_v
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // ray_x, ray_y, ray_z, pad
  logic                   cfg_we = 1'b0;
  logic [ADDR_W-1:0]      cfg_addr = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  ray_scoreboard sb = new();
  int send_idle_pct = 0;   // chance the sender skips a cycle
  int recv_stall_pct = 0;  // chance the receiver holds off a cycle
  int quiet_cycles = 0;

  pixel_to_unit_ray dut (.*);

  always #5 clk = ~clk;

  // Receiver: stall at random per the current idling mode
  always @(posedge clk) begin
    m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each ray as it leaves the block
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_ray(m_tdata);
  end

  // Watchdog: give up when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one pixel item and hold it until accepted
  task automatic send_pixel(input logic [PIX_W-1:0] u, input logic [PIX_W-1:0] v);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {v, u};
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(u, v);
  endtask

  // Drop valid and wait until every owed ray is out, then let the pipe empty
  task automatic drain_rays();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.owed_rays.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  // Write one register; the caller lowers cfg_we after the last write
  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_camera(input logic [CFG_W-1:0] fx, input logic [CFG_W-1:0] fy,
                              input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                              input logic [CFG_W-1:0] tx, input logic [CFG_W-1:0] ty);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_OFFSET_X, tx);
    write_reg(REG_OFFSET_Y, ty);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly pixels near the principal point, some anywhere in the field
  task automatic send_random_pixel();
    logic [PIX_W-1:0] u, v;
    if ($urandom_range(3) == 0) begin
      u = PIX_W'($urandom);
      v = PIX_W'($urandom);
    end else begin
      u = sb.center_x + PIX_W'($urandom_range(8191)) - PIX_W'(4096);
      v = sb.center_y + PIX_W'($urandom_range(8191)) - PIX_W'(4096);
    end
    send_pixel(u, v);
  endtask

  initial begin
    logic [CFG_W-1:0] fx, fy;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: corners, the principal point, one axis at a time
    send_pixel(16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'd0, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0);
    send_pixel(CENTER_X_RST, CENTER_Y_RST);
    send_pixel(CENTER_X_RST, 16'd0);
    send_pixel(16'd0, CENTER_Y_RST);
    send_pixel(16'hAAAA, 16'h5555);
    drain_rays();

    // Zero focal lengths act as one LSB; off-axis rays lie flat at full length
    write_camera(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    send_pixel(16'd0, 16'd0);
    send_pixel(16'd1, 16'd0);
    send_pixel(16'd0, 16'd1);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'd16, 16'd16);
    drain_rays();

    // Largest focal lengths, extreme offsets, wide center values trimmed,
    // and writes to spare indexes that must change nothing
    write_camera(24'hFFFFFF, 24'hFFFFFF, 24'hAB_FFFF, 24'h12_0000, 24'h800000, 24'h7FFFFF);
    write_reg(REG_SPARE_6, 24'h000100);
    write_reg(REG_SPARE_7, 24'h000100);
    cfg_we <= 1'b0;
    send_pixel(16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0);
    drain_rays();
    write_camera(24'd256, 24'd256, 24'd65535, 24'd0, 24'h7FFFFF, 24'h800000);
    send_pixel(16'd0, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0);
    send_pixel(16'h8000, 16'h8000);
    drain_rays();

    // Random camera sets, each under one idling mode
    for (int set = 0; set < NUM_SETS; set++) begin
      case (set % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (set == NUM_SETS - 1) begin
        fx = CFG_W'($urandom_range(24'hFFFFFF, 24'hF00000));
        fy = CFG_W'($urandom_range(255, 0));
      end else begin
        fx = CFG_W'($urandom_range(24'h100000, 24'h100));
        fy = CFG_W'($urandom_range(24'h100000, 24'h100));
      end
      write_camera(fx, fy, CFG_W'($urandom), CFG_W'($urandom),
                   CFG_W'($urandom_range(4095) - 2048),
                   (set % 2) ? CFG_W'($urandom) : CFG_W'($urandom_range(4095) - 2048));
      for (int i = 0; i < RAND_ITEMS / NUM_SETS; i++) begin
        send_random_pixel();
        // Mid-set hold-off: sender waits for every owed ray once
        if (set == 2 && i == 60) drain_rays();
      end
      drain_rays();
    end

    if (sb.errors == 0 && sb.owed_rays.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
